@@ rtl/core/lesf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lesf_pkg;

    localparam int COL_W  = 10;
    localparam int ROW_W  = 10;
    localparam int SIDE_W = 11;
    localparam int DIM_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0]  MAX_COLS = 11'd1024;
    localparam logic [DIM_W-1:0]  MAX_ROWS = 11'd1024;
    localparam logic [CHAR_W-1:0] OBSTACLE_CHAR = 8'd111;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COLS = 2'd0,
        CFG_NUM_ROWS = 2'd1
    } cfg_idx_t;

    // one cell on its way from the position counters to the side stage
    typedef struct packed {
        logic             obstacle;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             col_nz;
        logic             row_nz;
        logic             last;
    } cell_item_t;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [SIDE_W-1:0] data;
    } lb_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/lesf_line_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lesf_line_buf
    import lesf_pkg::*;
(
    input  wire logic              clk,
    input  wire lb_wr_t            wr,
    input  wire logic              rd_en,
    input  wire logic [COL_W-1:0]  rd_addr,
    output logic      [SIDE_W-1:0] rd_data
);

    logic [SIDE_W-1:0] mem [2**COL_W];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read-before-write: a same-address write is forwarded downstream
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lesf_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lesf_scan
    import lesf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 accept,
    input  wire logic [CHAR_W-1:0]    cell_char,
    output cell_item_t                item
);

    logic [DIM_W-1:0] num_cols_reg;
    logic [DIM_W-1:0] num_rows_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic             row_end;
    logic             map_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= MAX_COLS;
            num_rows_reg <= MAX_ROWS;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NUM_COLS: num_cols_reg <= cfg_data;
                CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cols = num_cols_reg;
        if (num_cols_reg == '0)
        begin
            cols = DIM_W'(1);
        end
        else if (num_cols_reg > MAX_COLS)
        begin
            cols = MAX_COLS;
        end
        rows = num_rows_reg;
        if (num_rows_reg == '0)
        begin
            rows = DIM_W'(1);
        end
        else if (num_rows_reg > MAX_ROWS)
        begin
            rows = MAX_ROWS;
        end

        row_end = (DIM_W'(col_reg) + DIM_W'(1)) >= cols;
        map_end = row_end && ((DIM_W'(row_reg) + DIM_W'(1)) >= rows);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (map_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end

        item.obstacle = (cell_char == OBSTACLE_CHAR);
        item.col      = col_reg;
        item.row      = row_reg;
        item.col_nz   = (col_reg != '0);
        item.row_nz   = (row_reg != '0);
        item.last     = map_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lesf_side.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lesf_side
    import lesf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire cell_item_t         item,
    input  wire logic [SIDE_W-1:0]  up_rd,
    output lb_wr_t                  lb_wr,
    output logic                    can_take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [ROW_W-1:0]   best_row,
    output logic      [COL_W-1:0]   best_col,
    output logic      [SIDE_W-1:0]  best_size
);

    cell_item_t        s1_reg;
    logic              s1_valid_reg;
    logic              fwd_reg;
    logic [SIDE_W-1:0] fwd_data_reg;
    logic [SIDE_W-1:0] left_reg;
    logic [SIDE_W-1:0] diag_reg;
    logic [SIDE_W-1:0] best_side_reg;
    logic [SIDE_W-1:0] best_side_next;
    logic [ROW_W-1:0]  best_bot_reg;
    logic [ROW_W-1:0]  best_bot_next;
    logic [COL_W-1:0]  best_rc_reg;
    logic [COL_W-1:0]  best_rc_next;
    logic              out_valid_reg;
    logic [SIDE_W-1:0] out_side_reg;
    logic [ROW_W-1:0]  out_bot_reg;
    logic [COL_W-1:0]  out_rc_reg;
    logic              s1_fire;
    logic [SIDE_W-1:0] up;
    logic [SIDE_W-1:0] left;
    logic [SIDE_W-1:0] diag;
    logic [SIDE_W-1:0] m;
    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] row_calc;
    logic [SIDE_W-1:0] col_calc;

    always_comb
    begin
        s1_fire  = s1_valid_reg && (!s1_reg.last || !out_valid_reg || out_ready);
        can_take = !s1_valid_reg || s1_fire;

        up   = s1_reg.row_nz ? (fwd_reg ? fwd_data_reg : up_rd) : '0;
        left = s1_reg.col_nz ? left_reg : '0;
        diag = (s1_reg.row_nz && s1_reg.col_nz) ? diag_reg : '0;
        m    = (up < left) ? up : left;
        m    = (m < diag) ? m : diag;
        side = s1_reg.obstacle ? '0 : m + SIDE_W'(1);

        best_side_next = best_side_reg;
        best_bot_next  = best_bot_reg;
        best_rc_next   = best_rc_reg;
        if (side > best_side_reg)
        begin
            best_side_next = side;
            best_bot_next  = s1_reg.row;
            best_rc_next   = s1_reg.col;
        end

        lb_wr.en   = s1_fire;
        lb_wr.addr = s1_reg.col;
        lb_wr.data = side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            best_side_reg <= '0;
            best_bot_reg  <= '0;
            best_rc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && s1_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                if (s1_reg.last)
                begin
                    best_side_reg <= '0;
                    best_bot_reg  <= '0;
                    best_rc_reg   <= '0;
                end
                else
                begin
                    best_side_reg <= best_side_next;
                    best_bot_reg  <= best_bot_next;
                    best_rc_reg   <= best_rc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= item;
            // write landing this cycle at the address being read
            fwd_reg      <= s1_fire && (s1_reg.col == item.col);
            fwd_data_reg <= side;
        end
        if (s1_fire)
        begin
            left_reg <= side;
            diag_reg <= up;
        end
        if (s1_fire && s1_reg.last)
        begin
            out_side_reg <= best_side_next;
            out_bot_reg  <= best_bot_next;
            out_rc_reg   <= best_rc_next;
        end
    end

    always_comb
    begin
        row_calc = SIDE_W'(out_bot_reg) + SIDE_W'(1) - out_side_reg;
        col_calc = SIDE_W'(out_rc_reg) + SIDE_W'(1) - out_side_reg;
        if (out_side_reg == '0)
        begin
            row_calc = '0;
            col_calc = '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_row  = row_calc[ROW_W-1:0];
    assign best_col  = col_calc[COL_W-1:0];
    assign best_size = out_side_reg;

endmodule

`default_nettype wire

@@ rtl/core/largest_empty_square_finder_top.sv @@
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------
// in       | in_valid / in_ready   | cell_char[7:0]
// out      | out_valid / out_ready | best_row[9:0] best_col[9:0] best_size[10:0]
// cfg      | cfg_valid / cfg_ready | cfg_index[1:0] cfg_data[10:0]
//
// One cell item per cycle while in_ready is high; the line buffer read is
// registered with the cell, then the min-of-three and the best update run on it.
// Reset clears counters, running best and valids; the line buffer needs no clear.
// in_ready drops only while the last cell of a map waits on a full output register.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module largest_empty_square_finder_top
    import lesf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CHAR_W-1:0]    cell_char,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [ROW_W-1:0]     best_row,
    output logic      [COL_W-1:0]     best_col,
    output logic      [SIDE_W-1:0]    best_size
);

    cell_item_t        item;
    lb_wr_t            lb_wr;
    logic [SIDE_W-1:0] up_rd;
    logic              accept;
    logic              can_take;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_take;
    assign accept    = in_valid && can_take;

    lesf_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cell_char (cell_char),
        .item      (item)
    );

    lesf_line_buf u_line_buf (
        .clk     (clk),
        .wr      (lb_wr),
        .rd_en   (accept),
        .rd_addr (item.col),
        .rd_data (up_rd)
    );

    lesf_side u_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .up_rd     (up_rd),
        .lb_wr     (lb_wr),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .best_row  (best_row),
        .best_col  (best_col),
        .best_size (best_size)
    );

    a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    a_empty_map_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && best_size == '0) |-> (best_row == '0 && best_col == '0))
        else $error("zero side with nonzero corner");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_size <= MAX_COLS))
        else $error("side exceeds map width");

endmodule

`default_nettype wire
